>>> hdl/caq_pkg.sv
// Package: shared constants, transaction types and controller commands for the circular queue.
`default_nettype none
package caq_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int MIN_CAPACITY  = 5;
  localparam int CAP_W         = 5;
  localparam int WORD_W        = 32;

  localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);

  localparam logic [2:0] FUNC_ENQ   = 3'd0;
  localparam logic [2:0] FUNC_DEQ   = 3'd1;
  localparam logic [2:0] FUNC_PEEK  = 3'd2;
  localparam logic [2:0] FUNC_RDDEQ = 3'd3;
  localparam logic [2:0] FUNC_CLEAR = 3'd4;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef struct packed {
    logic [2:0]               func;
    logic signed [WORD_W-1:0] data_in;
  } in_item_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] data_out;
    logic [1:0]               status;
    logic                     is_empty;
    logic                     is_full;
  } out_item_t;

  typedef struct packed {
    logic load;
    logic exec;
  } caq_cmd_t;

endpackage
`default_nettype wire

>>> hdl/circular_array_queue.sv
// Top level: ring-buffer queue of signed words with configurable wrap capacity.
//
//   channel | direction | handshake           | payload
//   in      | input     | in_valid / in_stall | in_data  (func, data_in)
//   out     | output    | out_valid/out_stall | out_data (data_out, status, is_empty, is_full)
//   cfg     | input     | cfg_write           | cfg_data (capacity)
//
// A transaction is handled in order: accept (slot read issued at the head index),
// execute (pointer update and slot write), then the result is shown until taken.
// The slot RAM has one write port and one read port, and its read data is registered.
// Reset (rst, synchronous) empties the queue and sets capacity to 16; slots keep no reset.
// While a result is stalled no new transaction is accepted.
`default_nettype none
module circular_array_queue
  import caq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output out_item_t             out_data,
  input  wire logic             cfg_write,
  input  wire logic [CAP_W-1:0] cfg_data
);

  caq_cmd_t cmd;

  caq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  caq_dp #(.DEPTH(DEPTH)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

>>> hdl/caq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module caq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hdl/caq_ctrl.sv
// Controller: sequences accept, execute and result delivery for one transaction at a time.
`default_nettype none
module caq_ctrl
  import caq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_stall,
  output logic      out_valid,
  input  wire logic out_stall,
  output caq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t state, state_next;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_EXEC;
      end
      S_EXEC: state_next = S_DONE;
      S_DONE: begin
        if (!out_stall) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_DONE);
  assign cmd.load  = (state == S_IDLE) && in_valid;
  assign cmd.exec  = (state == S_EXEC);

endmodule
`default_nettype wire

>>> hdl/caq_dp.sv
// Datapath: capacity register, ring pointers, occupancy, slot RAM and result register.
`default_nettype none
module caq_dp
  import caq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEFAULT
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire caq_cmd_t         cmd,
  input  wire in_item_t         in_data,
  input  wire logic             cfg_write,
  input  wire logic [CAP_W-1:0] cfg_data,
  output out_item_t             out_data
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = (CAP_W > IW + 1) ? CAP_W : IW + 1;

  logic [CAP_W-1:0] capacity;
  logic [IW-1:0]    head_index, head_index_next;
  logic [IW-1:0]    tail_index, tail_index_next;
  logic [CW-1:0]    occupancy, occupancy_next;
  logic [2:0]       func;
  logic [WORD_W-1:0] data_in;
  out_item_t        result_next;

  logic [WW-1:0]     cap_raw, eff_cap, occ_w, occ_next_w, head_inc, tail_inc;
  logic [IW-1:0]     head_adv, tail_adv;
  logic              full, empty, ram_we;
  logic [WORD_W-1:0] rdata;

  caq_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (tail_adv),
    .wdata (data_in),
    .re    (cmd.load),
    .raddr (head_index),
    .rdata (rdata)
  );

  // Clamp the configured capacity to MIN_CAPACITY .. DEPTH.
  always_comb begin
    cap_raw = WW'(capacity);
    if (cap_raw < WW'(MIN_CAPACITY)) begin
      eff_cap = WW'(MIN_CAPACITY);
    end else if (cap_raw > WW'(DEPTH)) begin
      eff_cap = WW'(DEPTH);
    end else begin
      eff_cap = cap_raw;
    end
  end

  // Wrap indices at the effective capacity.
  always_comb begin
    head_inc = WW'(head_index) + WW'(1);
    tail_inc = WW'(tail_index) + WW'(1);
    head_adv = (head_inc >= eff_cap) ? '0 : head_inc[IW-1:0];
    tail_adv = (tail_inc >= eff_cap) ? '0 : tail_inc[IW-1:0];
  end

  assign occ_w = WW'(occupancy);
  assign full  = (occ_w >= eff_cap);
  assign empty = (occupancy == '0);

  always_comb begin
    head_index_next      = head_index;
    tail_index_next      = tail_index;
    occupancy_next       = occupancy;
    ram_we               = 1'b0;
    result_next.data_out = '0;
    result_next.status   = STATUS_OK;
    case (func)
      FUNC_ENQ: begin
        if (full) begin
          result_next.status = STATUS_FULL;
        end else begin
          occupancy_next  = occupancy + CW'(1);
          tail_index_next = tail_adv;
          ram_we          = cmd.exec;
        end
      end
      FUNC_DEQ, FUNC_PEEK, FUNC_RDDEQ: begin
        if (empty) begin
          result_next.status = STATUS_EMPTY;
        end else begin
          if (func != FUNC_DEQ) result_next.data_out = rdata;
          if (func != FUNC_PEEK) begin
            occupancy_next  = occupancy - CW'(1);
            head_index_next = head_adv;
          end
        end
      end
      FUNC_CLEAR: begin
        occupancy_next  = '0;
        head_index_next = IW'(1);
        tail_index_next = '0;
      end
      default: ;
    endcase
    occ_next_w           = WW'(occupancy_next);
    result_next.is_empty = (occupancy_next == '0);
    result_next.is_full  = (occ_next_w >= eff_cap);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity   <= CAPACITY_RESET;
      head_index <= IW'(1);
      tail_index <= '0;
      occupancy  <= '0;
    end else begin
      if (cfg_write) capacity <= cfg_data;
      if (cmd.exec) begin
        head_index <= head_index_next;
        tail_index <= tail_index_next;
        occupancy  <= occupancy_next;
      end
    end
  end

  // Hold the transaction and its result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func    <= in_data.func;
      data_in <= in_data.data_in;
    end
    if (cmd.exec) begin
      out_data <= result_next;
    end
  end

endmodule
`default_nettype wire
